// ===== rtl/dense_prim_mst_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the dense Prim spanning tree unit.
// ---------------------------------------------------------------------------
`ifndef DENSE_PRIM_MST_UNIT_MACROS_SVH
`define DENSE_PRIM_MST_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DPM_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define DPM_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define DPM_ASSERT_IMPL(label, clk, rst_n, prop)
`define DPM_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/dpm_pkg.sv =====
// ---------------------------------------------------------------------------
// dpm_pkg
// Shared constants and types of the spanning tree unit.
// ---------------------------------------------------------------------------
package dpm_pkg;
    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int KEY_BITS   = COORD_BITS + FRAC_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS + 2;
    localparam int SQRT_STEPS = COORD_BITS + FRAC_BITS + 1;
    localparam int REM_BITS   = KEY_BITS + 2;
    localparam int STEP_BITS  = $clog2(SQRT_STEPS + 1);
    localparam logic [KEY_BITS-1:0] KEY_INF = '1;

    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_ROOT_VERTEX = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD, ST_INIT, ST_SCAN, ST_SCAN_CMP, ST_SCAN_END, ST_UPD_RD, ST_UPD_WAIT,
        ST_UPD_SQ, ST_UPD_SQRT, ST_UPD_WR, ST_EMIT_RD, ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_sqrt_ctl;
endpackage

// ===== rtl/dpm_ram.sv =====
// ---------------------------------------------------------------------------
// dpm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/dpm_sqrt.sv =====
// ---------------------------------------------------------------------------
// dpm_sqrt
// Digit-by-digit fixed point square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module dpm_sqrt (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [dpm_pkg::SQ_BITS-1:0]          i_sq,
    output dpm_pkg::t_sqrt_ctl                   o_ctl,
    output logic [dpm_pkg::KEY_BITS-1:0]         o_root
);
    import dpm_pkg::*;

    logic [SQ_BITS-1:0]   r_sq;
    logic [REM_BITS-1:0]  r_rem, n_rem;
    logic [KEY_BITS-1:0]  r_root, n_root;
    logic [STEP_BITS-1:0] r_step;
    logic                 r_busy;
    logic [REM_BITS-1:0]  w_acc, w_trial;

    // Pairs are taken from the top of the shifted square; zeros follow.
    always_comb begin
        w_acc   = {r_rem[REM_BITS-3:0], r_sq[SQ_BITS-1 -: 2]};
        w_trial = {r_root[KEY_BITS-1:0], 2'b01};
        if (w_acc >= w_trial) begin
            n_rem  = w_acc - w_trial;
            n_root = {r_root[KEY_BITS-2:0], 1'b1};
        end else begin
            n_rem  = w_acc;
            n_root = {r_root[KEY_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_BITS'(SQRT_STEPS - 1);
        end else if (r_busy) begin
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step - 1'b1;
        end
        if (i_start) begin
            r_sq   <= i_sq;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_sq   <= {r_sq[SQ_BITS-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_root      = r_root;
endmodule

// ===== rtl/dense_prim_mst_unit.sv =====
// ---------------------------------------------------------------------------
// dense_prim_mst_unit
// Minimum spanning tree of up to 64 planar points by dense Prim.
// ---------------------------------------------------------------------------
// Points load at one beat per cycle into coordinate RAMs. The beat that
// completes a point set starts the build, during which neither the input nor
// the configuration port is ready. The build first clears the visited and
// has-parent flags, then runs up to n rounds. Each round scans the n keys,
// reads the picked point and then visits every vertex; a vertex outside the
// tree waits on the shared one-bit-per-cycle square root unit, one already
// in the tree does not. After the build, n result beats leave in vertex
// order; a stalled beat is held unchanged. Keys and parents live in one RAM;
// a vertex whose has-parent flag is clear reads as an infinite key (zero for
// the root), so the RAM needs no clearing pass.
module dense_prim_mst_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [15:0]                         i_x_coord,
    input  logic [15:0]                         i_y_coord,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [6:0]                          i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [dpm_pkg::IDX_BITS-1:0]        o_vertex_index,
    output logic [dpm_pkg::IDX_BITS-1:0]        o_parent_vertex,
    output logic                                o_has_parent,
    output logic [dpm_pkg::KEY_BITS-1:0]        o_edge_length,
    output logic                                o_last_result
);
    import dpm_pkg::*;
    `include "dense_prim_mst_unit_macros.svh"

    t_state r_state, n_state;
    logic [6:0]          r_point_count;
    logic [5:0]          r_root_vertex;
    logic [CNT_BITS-1:0] r_load, r_n;
    logic [IDX_BITS-1:0] r_i, r_u;
    logic                r_found;
    logic [KEY_BITS-1:0] r_ukey;
    logic [MAX_POINTS-1:0] r_pv, r_in;
    logic [COORD_BITS-1:0] r_ux, r_uy;
    logic [SQ_BITS-1:0]  r_sq;
    logic                r_ph;
    logic                r_oval;

    // Effective point count and root.
    logic [CNT_BITS-1:0] w_n;
    logic [IDX_BITS-1:0] w_root;
    always_comb begin
        if (r_point_count == '0) w_n = CNT_BITS'(1);
        else if (r_point_count > 7'(MAX_POINTS)) w_n = CNT_BITS'(MAX_POINTS);
        else w_n = CNT_BITS'(r_point_count);
        w_root = (CNT_BITS'(r_root_vertex) < w_n) ? IDX_BITS'(r_root_vertex) : '0;
    end

    // Coordinate RAMs.
    logic                w_acc;
    logic [IDX_BITS-1:0] w_slot, w_raddr;
    logic [COORD_BITS-1:0] w_xr, w_yr;
    assign o_ready = (r_state == ST_LOAD);
    assign w_acc   = i_valid && o_ready;
    assign w_slot  = (r_load >= CNT_BITS'(MAX_POINTS)) ? IDX_BITS'(MAX_POINTS - 1)
                                                       : IDX_BITS'(r_load);
    assign w_raddr = r_i;
    dpm_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_xram (
        .i_clk(i_clk), .i_we(w_acc), .i_waddr(w_slot),
        .i_wdata(i_x_coord[COORD_BITS-1:0]), .i_raddr(w_raddr), .o_rdata(w_xr));
    dpm_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_yram (
        .i_clk(i_clk), .i_we(w_acc), .i_waddr(w_slot),
        .i_wdata(i_y_coord[COORD_BITS-1:0]), .i_raddr(w_raddr), .o_rdata(w_yr));

    // Square root unit.
    logic               w_sq_start;
    t_sqrt_ctl          w_sq_ctl;
    logic [KEY_BITS-1:0] w_dist;
    dpm_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start), .i_sq(r_sq),
        .o_ctl(w_sq_ctl), .o_root(w_dist));

    // Key and parent RAM, parent in the upper bits. The effective key of a
    // vertex without a parent is infinite, or zero for the root.
    logic                         w_twe;
    logic [KEY_BITS+IDX_BITS-1:0] w_tr;
    logic [KEY_BITS-1:0]          w_key_eff;
    dpm_ram #(.WIDTH(KEY_BITS + IDX_BITS), .DEPTH(MAX_POINTS)) u_tram (
        .i_clk(i_clk), .i_we(w_twe), .i_waddr(r_i),
        .i_wdata({r_u, w_dist}), .i_raddr(w_raddr), .o_rdata(w_tr));
    assign w_key_eff = r_pv[r_i] ? w_tr[KEY_BITS-1:0] : ((r_i == w_root) ? '0 : KEY_INF);
    assign w_twe     = (r_state == ST_UPD_WR) && !r_in[r_i] && (w_dist < w_key_eff);

    logic [IDX_BITS-1:0] w_last_i;
    logic [COORD_BITS-1:0] w_dx, w_dy;
    logic [2*COORD_BITS-1:0] w_dx2, w_dy2;
    assign w_last_i = IDX_BITS'(r_n - 1'b1);
    assign w_dx = (r_ux >= w_xr) ? r_ux - w_xr : w_xr - r_ux;
    assign w_dy = (r_uy >= w_yr) ? r_uy - w_yr : w_yr - r_uy;
    assign w_dx2 = {{COORD_BITS{1'b0}}, w_dx} * {{COORD_BITS{1'b0}}, w_dx};
    assign w_dy2 = {{COORD_BITS{1'b0}}, w_dy} * {{COORD_BITS{1'b0}}, w_dy};

    always_comb begin
        n_state    = r_state;
        w_sq_start = 1'b0;
        case (r_state)
            ST_LOAD:     if (w_acc && (r_load + 1'b1 >= w_n)) n_state = ST_INIT;
            ST_INIT:     n_state = ST_SCAN;
            ST_SCAN:     n_state = ST_SCAN_CMP;
            ST_SCAN_CMP: n_state = (r_i == w_last_i) ? ST_SCAN_END : ST_SCAN;
            ST_SCAN_END: n_state = r_found ? ST_UPD_RD : ST_EMIT_RD;
            ST_UPD_RD:   n_state = ST_UPD_WAIT;
            ST_UPD_WAIT: n_state = r_ph ? ST_UPD_SQ : ST_UPD_RD;
            ST_UPD_SQ: begin
                w_sq_start = !r_in[r_i];
                n_state    = r_in[r_i] ? ST_UPD_WR : ST_UPD_SQRT;
            end
            ST_UPD_SQRT: if (!w_sq_ctl.busy) n_state = ST_UPD_WR;
            ST_UPD_WR:   n_state = (r_i == w_last_i) ? ST_SCAN : ST_UPD_RD;
            ST_EMIT_RD:  n_state = ST_EMIT;
            ST_EMIT:     if (i_ready) n_state = (r_i == w_last_i) ? ST_LOAD : ST_EMIT_RD;
            default:     n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_LOAD;
            r_point_count <= 7'd64;
            r_root_vertex <= '0;
            r_load        <= '0;
            r_oval        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POINT_COUNT: r_point_count <= i_cfg_data;
                    CFG_ROOT_VERTEX: r_root_vertex <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (w_acc) begin
                r_load <= (r_load + 1'b1 >= w_n) ? '0 : CNT_BITS'(w_slot) + 1'b1;
            end
            if (n_state == ST_EMIT && !(r_state == ST_EMIT && !i_ready)) r_oval <= 1'b1;
            else if (r_state == ST_EMIT && i_ready) r_oval <= 1'b0;
        end
        // Datapath and tree state; the load, build and emit states update them.
        case (r_state)
            ST_LOAD: begin
                r_n <= w_n;
                r_i <= '0;
            end
            ST_INIT: begin
                r_pv    <= '0;
                r_in    <= '0;
                r_found <= 1'b0;
                r_i     <= '0;
            end
            ST_SCAN: ;
            ST_SCAN_CMP: begin
                // Only a strictly smaller key displaces the pick, so the
                // lowest index wins a tie.
                if (!r_in[r_i] && (!r_found || w_key_eff < r_ukey)) begin
                    r_u     <= r_i;
                    r_ukey  <= w_key_eff;
                    r_found <= 1'b1;
                end
                r_i <= (r_i == w_last_i) ? '0 : r_i + 1'b1;
            end
            ST_SCAN_END: begin
                r_i <= r_found ? r_u : '0;
                if (r_found) r_in[r_u] <= 1'b1;
            end
            ST_UPD_RD: ;
            ST_UPD_WAIT: begin
                // The first read of a round fetches the picked point; the
                // pass over all vertices then starts again from vertex 0.
                if (r_ph == 1'b0) begin
                    r_ux <= w_xr;
                    r_uy <= w_yr;
                    r_i  <= '0;
                end else begin
                    r_sq <= SQ_BITS'(w_dx2) + SQ_BITS'(w_dy2);
                end
            end
            ST_UPD_WR: begin
                if (w_twe) r_pv[r_i] <= 1'b1;
                if (r_i == w_last_i) begin
                    r_i     <= '0;
                    r_found <= 1'b0;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            ST_EMIT: if (i_ready) r_i <= r_i + 1'b1;
            default: ;
        endcase
        // r_ph marks whether the picked vertex coordinates are captured.
        if (r_state == ST_SCAN_END) r_ph <= 1'b0;
        else if (r_state == ST_UPD_WAIT && r_ph == 1'b0) r_ph <= 1'b1;
    end

    assign o_cfg_ready     = (r_state == ST_LOAD);
    assign o_valid         = r_oval;
    assign o_vertex_index  = r_i;
    assign o_parent_vertex = r_pv[r_i] ? w_tr[KEY_BITS +: IDX_BITS] : '0;
    assign o_has_parent    = r_pv[r_i];
    assign o_edge_length   = r_pv[r_i] ? w_tr[KEY_BITS-1:0] : '0;
    assign o_last_result   = (r_i == w_last_i);

    `DPM_ASSERT_NEVER(a_no_in_while_busy, i_clk, i_rst_n, o_valid && o_ready)
    `DPM_ASSERT_IMPL(a_sqrt_only_in_update, i_clk, i_rst_n,
        w_sq_ctl.busy |-> (r_state == ST_UPD_SQRT))
    `DPM_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n,
        (o_valid && !i_ready) |=> (o_valid && $stable(o_vertex_index)))
endmodule
